[design/fvt_pkg.sv]
// shared types, constants and helpers for the fixed-point vertex transform
// no dependencies; imported by every module of the block

package fvt_pkg;

   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 8;
   localparam int MAT_DIM   = 4;
   localparam int IDX_W     = 4;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 96;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;

   // row-major 4x4 matrix, entry i at [i]
   typedef word_type [MAT_DIM*MAT_DIM-1:0] mat_type;
   // four rows (or columns) of four words
   typedef word_type [MAT_DIM-1:0][MAT_DIM-1:0] grid_type;

   typedef enum logic [1:0] {
      FUNC_WR_WORLD = 2'd0,
      FUNC_WR_VIEW  = 2'd1,
      FUNC_VERTEX   = 2'd2
   } func_type;

   // matrix entry write toward the matrix unit
   typedef struct packed {
      logic     en;
      logic     view_sel;
      idx_type  idx;
      word_type value;
   } mat_wr_type;

   // arithmetic shift that drops the fraction bits of a wrapped product
   function automatic word_type fx_shift(input word_type p);
      word_type s;
      s = word_type'($signed(p) >>> FRAC_BITS);
      return s;
   endfunction

endpackage

[design/fvt_matrix_unit.sv]
// world and view matrix storage plus the pipelined world-times-view rebuild
// depends on fvt_pkg

module fvt_matrix_unit (
   input  logic               clock,
   input  logic               reset,
   input  fvt_pkg::mat_wr_type wr,
   output fvt_pkg::mat_type   final_mat,
   output logic               busy
);
   import fvt_pkg::*;

   grid_type world_ff, world_in;   // [row][k] = world[4*row + k]
   grid_type viewc_ff, viewc_in;   // [col][k] = view[col + 4*k]
   mat_type  final_ff, final_in;

   logic    issue_ff, issue_in;
   idx_type cnt_ff, cnt_in;

   logic     va_ff, va_in;
   idx_type  ia_ff, ia_in;
   word_type [MAT_DIM-1:0] pa_ff, pa_in;

   logic     vb_ff, vb_in;
   idx_type  ib_ff, ib_in;
   word_type [1:0] sb_ff, sb_in;

   word_type [MAT_DIM-1:0] wrow;
   word_type [MAT_DIM-1:0] vcol;

   // storage writes
   always_comb begin
      world_in = world_ff;
      viewc_in = viewc_ff;
      if (wr.en) begin
         if (wr.view_sel) begin
            viewc_in[wr.idx[1:0]][wr.idx[3:2]] = wr.value;
         end else begin
            world_in[wr.idx[3:2]][wr.idx[1:0]] = wr.value;
         end
      end
   end

   // entry sequencer: one final entry per cycle
   always_comb begin
      issue_in = issue_ff;
      cnt_in   = cnt_ff;
      if (wr.en) begin
         issue_in = 1'b1;
         cnt_in   = '0;
      end else if (issue_ff) begin
         cnt_in = cnt_ff + idx_type'(1);
         if (cnt_ff == '1) begin
            issue_in = 1'b0;
         end
      end
   end

   assign wrow = world_ff[cnt_ff[3:2]];
   assign vcol = viewc_ff[cnt_ff[1:0]];

   // stage a: four products
   always_comb begin
      va_in = issue_ff;
      ia_in = cnt_ff;
      for (int k = 0; k < MAT_DIM; k++) begin
         pa_in[k] = word_type'(vcol[k] * wrow[k]);
      end
   end

   // stage b: shift and pairwise sums
   always_comb begin
      vb_in    = va_ff;
      ib_in    = ia_ff;
      sb_in[0] = fx_shift(pa_ff[0]) + fx_shift(pa_ff[1]);
      sb_in[1] = fx_shift(pa_ff[2]) + fx_shift(pa_ff[3]);
   end

   // stage c: write the final entry
   always_comb begin
      final_in = final_ff;
      if (vb_ff) begin
         final_in[ib_ff] = sb_ff[0] + sb_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         world_ff <= '0;
         viewc_ff <= '0;
         final_ff <= '0;
         issue_ff <= 1'b0;
         cnt_ff   <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
      end else begin
         world_ff <= world_in;
         viewc_ff <= viewc_in;
         final_ff <= final_in;
         issue_ff <= issue_in;
         cnt_ff   <= cnt_in;
         va_ff    <= va_in;
         vb_ff    <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      ia_ff <= ia_in;
      pa_ff <= pa_in;
      ib_ff <= ib_in;
      sb_ff <= sb_in;
   end

   assign final_mat = final_ff;
   assign busy      = issue_ff | va_ff | vb_ff;

endmodule

[design/fvt_vertex_pipe.sv]
// three-stage vertex pipeline: multiply, shift and add, final add with output register
// depends on fvt_pkg

module fvt_vertex_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  fvt_pkg::word_type in_x,
   input  fvt_pkg::word_type in_y,
   input  fvt_pkg::word_type in_z,
   input  logic             in_last,
   input  fvt_pkg::mat_type final_mat,
   output logic             advance,
   output logic             out_valid,
   input  logic             out_ready,
   output fvt_pkg::word_type out_x,
   output fvt_pkg::word_type out_y,
   output fvt_pkg::word_type out_z,
   output logic             out_last
);
   import fvt_pkg::*;

   localparam int AXES = 3;

   // stage 1: products [axis][term] and translation
   logic     v1_ff, v1_in;
   logic     l1_ff, l1_in;
   word_type [AXES-1:0][AXES-1:0] p1_ff, p1_in;
   word_type [AXES-1:0] t1_ff, t1_in;

   // stage 2: partial sums
   logic     v2_ff, v2_in;
   logic     l2_ff, l2_in;
   word_type [AXES-1:0] a2_ff, a2_in;
   word_type [AXES-1:0] b2_ff, b2_in;

   // stage 3: result register
   logic     v3_ff, v3_in;
   logic     l3_ff, l3_in;
   word_type [AXES-1:0] r3_ff, r3_in;

   word_type [AXES-1:0] coord;

   assign advance = ~v3_ff | out_ready;
   assign coord   = {in_z, in_y, in_x};

   always_comb begin
      v1_in = in_valid;
      l1_in = in_last;
      for (int a = 0; a < AXES; a++) begin
         for (int t = 0; t < AXES; t++) begin
            p1_in[a][t] = word_type'(final_mat[a + MAT_DIM*t] * coord[t]);
         end
         t1_in[a] = final_mat[a + MAT_DIM*AXES];
      end
   end

   always_comb begin
      v2_in = v1_ff;
      l2_in = l1_ff;
      for (int a = 0; a < AXES; a++) begin
         a2_in[a] = fx_shift(p1_ff[a][0]) + fx_shift(p1_ff[a][1]);
         b2_in[a] = fx_shift(p1_ff[a][2]) + t1_ff[a];
      end
   end

   always_comb begin
      v3_in = v2_ff;
      l3_in = l2_ff;
      for (int a = 0; a < AXES; a++) begin
         r3_in[a] = a2_ff[a] + b2_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l1_ff <= l1_in;
         p1_ff <= p1_in;
         t1_ff <= t1_in;
         l2_ff <= l2_in;
         a2_ff <= a2_in;
         b2_ff <= b2_in;
         l3_ff <= l3_in;
         r3_ff <= r3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_x     = r3_ff[0];
   assign out_y     = r3_ff[1];
   assign out_z     = r3_ff[2];
   assign out_last  = l3_ff;

endmodule

[design/fixed_point_vertex_transform_unit.sv]
// top level of the fixed-point 4x4 matrix vertex transform
// depends on fvt_pkg, fvt_matrix_unit and fvt_vertex_pipe

// The unit keeps a world and a view matrix of signed 24.8 words and transforms
// vertices by their product. Each request item carries a function code in
// req_tuser: write a world entry, write a view entry, or transform a vertex
// (code 3 is taken and dropped). While no rebuild runs and the output is not
// stalled, vertices stream at one item per cycle through a three-stage
// pipeline (multiply, shift and add, final add into the output register) and
// come out in order, with req_tlast copied to rsp_tlast. A stalled rsp_tready
// freezes the whole pipeline without loss. Every matrix write starts a
// rebuild of world times view: four multipliers produce one final entry per
// cycle, all sixteen in turn, plus two drain stages; req_tready stays low
// until the rebuild is done. Vertices already in flight keep the coefficients
// they were accepted with. All arithmetic wraps at 32 bits; products keep their
// low 32 bits and are shifted right arithmetically by 8 before summing.

module fixed_point_vertex_transform_unit (
   input  logic clock,
   input  logic reset,

   // request item
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index [3:0], entry_value [35:4], vert_x [67:36], vert_y [99:68],
   // vert_z [131:100], zero pad [135:132]
   input  logic [fvt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func [1:0]
   input  logic [1:0]                        req_tuser,
   // last_in
   input  logic                              req_tlast,

   // result item
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x [31:0], out_y [63:32], out_z [95:64]
   output logic [fvt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // last_out
   output logic                              rsp_tlast
);
   import fvt_pkg::*;

   logic       accept;
   func_type   func;
   mat_wr_type wr;
   mat_type    final_mat;
   logic       busy;
   logic       advance;
   logic       vert_valid;
   word_type   out_x, out_y, out_z;

   // items are taken only while no rebuild runs and the pipeline can move
   assign req_tready = advance & ~busy;
   assign accept     = req_tvalid & req_tready;
   assign func       = func_type'(req_tuser);

   // matrix entry writes go straight to storage and kick off the rebuild
   assign wr.en       = accept & ((func == FUNC_WR_WORLD) | (func == FUNC_WR_VIEW));
   assign wr.view_sel = (func == FUNC_WR_VIEW);
   assign wr.idx      = req_tdata[3:0];
   assign wr.value    = req_tdata[35:4];

   assign vert_valid = accept & (func == FUNC_VERTEX);

   fvt_matrix_unit u_matrix (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .final_mat (final_mat),
      .busy      (busy)
   );

   fvt_vertex_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vert_valid),
      .in_x      (req_tdata[67:36]),
      .in_y      (req_tdata[99:68]),
      .in_z      (req_tdata[131:100]),
      .in_last   (req_tlast),
      .final_mat (final_mat),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_z     (out_z),
      .out_last  (rsp_tlast)
   );

   // result packing, x in the low word
   assign rsp_tdata = {out_z, out_y, out_x};

endmodule
